>>> hdl/tbli_pkg.sv
// Shared constants, types and codes for the table bisection interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tbli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int INDEX_W     = 8;
   localparam int VALUE_W     = 32;
   localparam int FRAC_BITS   = 16;
   localparam int UNIT_W      = FRAC_BITS + 1;
   localparam int STEP_W      = $clog2(FRAC_BITS);
   localparam int DIFF_W      = VALUE_W + 1;
   localparam int PROD_W      = DIFF_W + UNIT_W + 1;
   localparam int STATUS_W    = 2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] time_val;
      logic signed [VALUE_W-1:0] rho;
      logic signed [VALUE_W-1:0] vel;
      logic signed [VALUE_W-1:0] sigma;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_ZERO_BIN = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      LANE_RHO   = 2'd0,
      LANE_VEL   = 2'd1,
      LANE_SIGMA = 2'd2
   } lane_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_BISECT,
      ST_COMPARE,
      ST_BIN,
      ST_PREP,
      ST_DIVIDE,
      ST_BLEND,
      ST_FLUSH,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hdl/tbli_req_if.sv
// Input channel of the interpolator: row loads and queries.
`timescale 1ns / 1ps
`default_nettype none

interface tbli_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [tbli_pkg::INDEX_W-1:0]        entry_index;
   logic signed [tbli_pkg::VALUE_W-1:0] entry_time;
   logic signed [tbli_pkg::VALUE_W-1:0] entry_rho;
   logic signed [tbli_pkg::VALUE_W-1:0] entry_vel;
   logic signed [tbli_pkg::VALUE_W-1:0] entry_sigma;
   logic signed [tbli_pkg::VALUE_W-1:0] query_time;

   modport source (
      output valid, func, entry_index, entry_time, entry_rho, entry_vel, entry_sigma,
             query_time,
      input  ready
   );
   modport sink (
      input  valid, func, entry_index, entry_time, entry_rho, entry_vel, entry_sigma,
             query_time,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/tbli_rsp_if.sv
// Result channel of the interpolator: interpolated values and status.
`timescale 1ns / 1ps
`default_nettype none

interface tbli_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tbli_pkg::VALUE_W-1:0]  out_rho;
   logic signed [tbli_pkg::VALUE_W-1:0]  out_vel;
   logic signed [tbli_pkg::VALUE_W-1:0]  out_sigma;
   logic [tbli_pkg::STATUS_W-1:0]        status;

   modport source (
      output valid, out_rho, out_vel, out_sigma, status,
      input  ready
   );
   modport sink (
      input  valid, out_rho, out_vel, out_sigma, status,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/table_bisect_linear_interp.sv
// Top level of the table bisection interpolator.
//
// The block keeps a time-sorted table of rows (time, density, velocity,
// dispersion) in one wide RAM and interpolates linearly between rows.
// The req channel carries two kinds of transfer. A load writes one row at
// entry_index and produces no result. A query searches rows below
// entry_count by bisection, one RAM read and one compare per step, divides
// the offset into the bin by the bin width one quotient bit per cycle, and
// blends the three values through one shared multiplier. On a full table a
// query reads the two table ends, takes up to eight bisection steps and a
// closing probe, forms the bin, runs sixteen division steps, then blends
// and loads the output register; a clamped fraction skips the division.
// Queries that fall outside the table end after the end-row reads. Only
// one query is worked on at a time; loads are taken one per cycle while
// idle. The result sits in an output register, so the block goes back to
// idle and takes further loads while a result waits for the receiver; a
// second query then holds in its final state until that register is free.
// Reset clears entry_count and the control state; table contents are
// undefined until loaded. csr_wr_en writes entry_count; the user must
// assert it only while idle, since the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module table_bisect_linear_interp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tbli_req_if.sink                           req_chan,
   tbli_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [tbli_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int AW = tbli_pkg::ADDR_W;
   localparam int VW = tbli_pkg::VALUE_W;
   localparam int DW = tbli_pkg::DIFF_W;
   localparam int UW = tbli_pkg::UNIT_W;
   localparam int PW = tbli_pkg::PROD_W;
   localparam int FB = tbli_pkg::FRAC_BITS;
   localparam int SW = tbli_pkg::STEP_W;

   // Control state.
   tbli_pkg::state_type             state_ff, state_in;
   logic [tbli_pkg::COUNT_W-1:0]    count_ff;
   logic                            prod_vld_ff, prod_vld_in;
   logic                            rsp_vld_ff;

   // Working registers of the query in flight.
   logic signed [VW-1:0]            t_ff, t_in;
   logic [AW-1:0]                   last_ff, last_in;
   logic [AW-1:0]                   low_ff, low_in;
   logic [AW-1:0]                   high_ff, high_in;
   logic [AW-1:0]                   mid_ff, mid_in;
   tbli_pkg::row_type               lo_row_ff, lo_row_in;
   tbli_pkg::row_type               hi_row_ff, hi_row_in;
   logic signed [DW-1:0]            num_ff, num_in;
   logic signed [DW-1:0]            den_ff, den_in;
   logic [DW-1:0]                   den_mag_ff, den_mag_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [UW-1:0]                   u_ff, u_in;
   logic [SW-1:0]                   step_ff, step_in;
   tbli_pkg::lane_type              lane_ff, lane_in;
   tbli_pkg::lane_type              prod_lane_ff;
   logic signed [PW-1:0]            prod_ff, prod_in;
   tbli_pkg::status_type            status_ff, status_in;
   logic signed [VW-1:0]            res_rho_ff, res_vel_ff, res_sigma_ff;

   // Output register.
   logic signed [VW-1:0]            rsp_rho_ff, rsp_vel_ff, rsp_sigma_ff;
   tbli_pkg::status_type            rsp_status_ff;

   // RAM ports.
   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_rd_addr;
   tbli_pkg::row_type               ram_wr_row;
   tbli_pkg::row_type               ram_rd_row;
   logic [tbli_pkg::ROW_W-1:0]      ram_rd_data;

   // Helpers.
   logic                            req_fire;
   logic                            rsp_free;
   logic                            rsp_load;
   logic [tbli_pkg::COUNT_W-1:0]    count_clamped;
   logic [AW:0]                     mid_sum;
   logic [AW-1:0]                   gap;
   logic                            num_neg, den_neg;
   logic [DW-1:0]                   num_mag, den_mag;
   logic [DW:0]                     rem_shift;
   logic                            rem_ge;
   logic signed [VW-1:0]            blend_a, blend_b;
   logic signed [DW-1:0]            blend_diff;
   logic signed [VW-1:0]            acc_a, acc_val;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_vld_ff || rsp_chan.ready;
   assign rsp_load = (state_ff == tbli_pkg::ST_DONE) && rsp_free;

   // A count above the table depth reads as the full table.
   assign count_clamped = (count_ff > tbli_pkg::COUNT_W'(tbli_pkg::TABLE_DEPTH)) ?
                          tbli_pkg::COUNT_W'(tbli_pkg::TABLE_DEPTH) : count_ff;

   // Table storage: one row per word.
   assign ram_wr_en  = req_fire && (req_chan.func == tbli_pkg::FUNC_LOAD);
   assign ram_wr_row = '{time_val: req_chan.entry_time,
                         rho:      req_chan.entry_rho,
                         vel:      req_chan.entry_vel,
                         sigma:    req_chan.entry_sigma};
   assign ram_rd_row = tbli_pkg::row_type'(ram_rd_data);

   tbli_ram #(
      .WIDTH (tbli_pkg::ROW_W),
      .DEPTH (tbli_pkg::TABLE_DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_chan.entry_index[AW-1:0]),
      .wr_data (ram_wr_row),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Bisection, sign handling and divider arithmetic.
   assign mid_sum   = {1'b0, high_ff} + {1'b0, low_ff};
   assign gap       = high_ff - low_ff;
   assign num_neg   = num_ff[DW-1];
   assign den_neg   = den_ff[DW-1];
   assign num_mag   = num_neg ? DW'(-num_ff) : DW'(num_ff);
   assign den_mag   = den_neg ? DW'(-den_ff) : DW'(den_ff);
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_mag_ff};

   // Operand selection for the shared multiplier.
   always_comb begin
      case (lane_ff)
         tbli_pkg::LANE_RHO: begin
            blend_a = lo_row_ff.rho;
            blend_b = hi_row_ff.rho;
         end
         tbli_pkg::LANE_VEL: begin
            blend_a = lo_row_ff.vel;
            blend_b = hi_row_ff.vel;
         end
         tbli_pkg::LANE_SIGMA: begin
            blend_a = lo_row_ff.sigma;
            blend_b = hi_row_ff.sigma;
         end
         default: begin
            blend_a = lo_row_ff.rho;
            blend_b = hi_row_ff.rho;
         end
      endcase
   end

   // The blend a*(1-u) + b*u equals a + (b-a)*u, and since the first term
   // has no fraction bits the floor shift only touches the product.
   assign blend_diff = DW'(blend_b) - DW'(blend_a);

   always_comb begin
      case (prod_lane_ff)
         tbli_pkg::LANE_RHO:   acc_a = lo_row_ff.rho;
         tbli_pkg::LANE_VEL:   acc_a = lo_row_ff.vel;
         tbli_pkg::LANE_SIGMA: acc_a = lo_row_ff.sigma;
         default:              acc_a = lo_row_ff.rho;
      endcase
   end

   assign acc_val = acc_a + prod_ff[VW+FB-1:FB];

   // Next state and datapath control.
   always_comb begin
      state_in    = state_ff;
      t_in        = t_ff;
      last_in     = last_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      mid_in      = mid_ff;
      lo_row_in   = lo_row_ff;
      hi_row_in   = hi_row_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      den_mag_in  = den_mag_ff;
      rem_in      = rem_ff;
      u_in        = u_ff;
      step_in     = step_ff;
      lane_in     = lane_ff;
      status_in   = status_ff;
      prod_in     = prod_ff;
      prod_vld_in = 1'b0;
      ram_rd_addr = '0;
      req_chan.ready = 1'b0;

      case (state_ff)
         tbli_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            ram_rd_addr    = '0;
            if (req_chan.valid && (req_chan.func == tbli_pkg::FUNC_QUERY)) begin
               t_in      = req_chan.query_time;
               last_in   = AW'(count_clamped - tbli_pkg::COUNT_W'(1));
               status_in = tbli_pkg::STATUS_OK;
               if (count_clamped == '0) begin
                  status_in = tbli_pkg::STATUS_RANGE;
                  state_in  = tbli_pkg::ST_DONE;
               end else begin
                  state_in  = tbli_pkg::ST_FIRST;
               end
            end
         end
         tbli_pkg::ST_FIRST: begin
            lo_row_in   = ram_rd_row;
            ram_rd_addr = last_ff;
            state_in    = tbli_pkg::ST_LAST;
         end
         tbli_pkg::ST_LAST: begin
            hi_row_in = ram_rd_row;
            low_in    = '0;
            high_in   = last_ff;
            if ((t_ff < lo_row_ff.time_val) || (t_ff > ram_rd_row.time_val)) begin
               status_in = tbli_pkg::STATUS_RANGE;
               state_in  = tbli_pkg::ST_DONE;
            end else begin
               state_in  = tbli_pkg::ST_BISECT;
            end
         end
         tbli_pkg::ST_BISECT: begin
            ram_rd_addr = mid_sum[AW:1];
            mid_in      = mid_sum[AW:1];
            if (gap > AW'(1)) begin
               state_in = tbli_pkg::ST_COMPARE;
            end else begin
               state_in = tbli_pkg::ST_BIN;
            end
         end
         tbli_pkg::ST_COMPARE: begin
            if (t_ff < ram_rd_row.time_val) begin
               high_in   = mid_ff;
               hi_row_in = ram_rd_row;
            end else begin
               low_in    = mid_ff;
               lo_row_in = ram_rd_row;
            end
            state_in = tbli_pkg::ST_BISECT;
         end
         tbli_pkg::ST_BIN: begin
            den_in = DW'(hi_row_ff.time_val) - DW'(lo_row_ff.time_val);
            num_in = DW'(t_ff) - DW'(lo_row_ff.time_val);
            if (hi_row_ff.time_val == lo_row_ff.time_val) begin
               status_in = tbli_pkg::STATUS_ZERO_BIN;
               state_in  = tbli_pkg::ST_DONE;
            end else begin
               state_in  = tbli_pkg::ST_PREP;
            end
         end
         tbli_pkg::ST_PREP: begin
            den_mag_in = den_mag;
            rem_in     = num_mag;
            step_in    = '0;
            lane_in    = tbli_pkg::LANE_RHO;
            if ((num_ff == '0) || (num_neg != den_neg)) begin
               u_in     = '0;
               state_in = tbli_pkg::ST_BLEND;
            end else if (num_mag >= den_mag) begin
               u_in     = UW'(1) << FB;
               state_in = tbli_pkg::ST_BLEND;
            end else begin
               u_in     = '0;
               state_in = tbli_pkg::ST_DIVIDE;
            end
         end
         tbli_pkg::ST_DIVIDE: begin
            // Restoring division, one quotient bit per cycle.
            rem_in  = rem_ge ? DW'(rem_shift - {1'b0, den_mag_ff}) : DW'(rem_shift);
            u_in    = {u_ff[UW-2:0], rem_ge};
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(FB - 1)) begin
               state_in = tbli_pkg::ST_BLEND;
            end
         end
         tbli_pkg::ST_BLEND: begin
            prod_in     = PW'(blend_diff) * PW'($signed({1'b0, u_ff}));
            prod_vld_in = 1'b1;
            case (lane_ff)
               tbli_pkg::LANE_RHO:   lane_in = tbli_pkg::LANE_VEL;
               tbli_pkg::LANE_VEL:   lane_in = tbli_pkg::LANE_SIGMA;
               tbli_pkg::LANE_SIGMA: state_in = tbli_pkg::ST_FLUSH;
               default:              state_in = tbli_pkg::ST_FLUSH;
            endcase
         end
         tbli_pkg::ST_FLUSH: begin
            state_in = tbli_pkg::ST_DONE;
         end
         tbli_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = tbli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbli_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tbli_pkg::ST_IDLE;
         count_ff    <= '0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= prod_vld_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      last_ff      <= last_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      lo_row_ff    <= lo_row_in;
      hi_row_ff    <= hi_row_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      den_mag_ff   <= den_mag_in;
      rem_ff       <= rem_in;
      u_ff         <= u_in;
      step_ff      <= step_in;
      lane_ff      <= lane_in;
      status_ff    <= status_in;
      prod_ff      <= prod_in;
      prod_lane_ff <= lane_ff;
      if (prod_vld_ff) begin
         case (prod_lane_ff)
            tbli_pkg::LANE_RHO:   res_rho_ff   <= acc_val;
            tbli_pkg::LANE_VEL:   res_vel_ff   <= acc_val;
            tbli_pkg::LANE_SIGMA: res_sigma_ff <= acc_val;
            default:              res_rho_ff   <= acc_val;
         endcase
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         if (status_ff == tbli_pkg::STATUS_OK) begin
            rsp_rho_ff   <= res_rho_ff;
            rsp_vel_ff   <= res_vel_ff;
            rsp_sigma_ff <= res_sigma_ff;
         end else begin
            rsp_rho_ff   <= '0;
            rsp_vel_ff   <= '0;
            rsp_sigma_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.out_rho   = rsp_rho_ff;
   assign rsp_chan.out_vel   = rsp_vel_ff;
   assign rsp_chan.out_sigma = rsp_sigma_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // A row load never starts a search.
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.func == tbli_pkg::FUNC_LOAD)) |=>
         (state_ff == tbli_pkg::ST_IDLE))
      else $error("row load left the idle state");

   // The probed row lies strictly inside the bracketing pair.
   a_mid_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbli_pkg::ST_COMPARE) |-> ((low_ff < mid_ff) && (mid_ff < high_ff)))
      else $error("bisection probe outside the bracket");

   // The divider remainder stays below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbli_pkg::ST_DIVIDE) |-> (rem_ff < den_mag_ff))
      else $error("divider remainder not below divisor");

   // A finished query waits while the output register holds an untaken result.
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tbli_pkg::ST_DONE) && rsp_vld_ff && !rsp_chan.ready) |=>
         ((state_ff == tbli_pkg::ST_DONE) && $stable(rsp_rho_ff)))
      else $error("output register overwritten before transfer");

   // An error result carries zero values.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_status_ff != tbli_pkg::STATUS_OK)) |->
         ((rsp_rho_ff == '0) && (rsp_vel_ff == '0) && (rsp_sigma_ff == '0)))
      else $error("error result with non-zero values");

endmodule

`default_nettype wire

>>> hdl/tbli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tbli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the table bisection interpolator.
`timescale 1ns / 1ps

module tb_top;

   localparam int VALUE_W     = tbli_pkg::VALUE_W;
   localparam int COUNT_W     = tbli_pkg::COUNT_W;
   localparam int INDEX_W     = tbli_pkg::INDEX_W;
   localparam int TABLE_DEPTH = tbli_pkg::TABLE_DEPTH;
   localparam int FRAC_BITS   = tbli_pkg::FRAC_BITS;

   // Clock, settle and reporting constants. The settle time is long enough
   // to cover anything still in flight.
   localparam int     CLOCK_HALF    = 5;
   localparam int     SETTLE_CYCLES = 64;
   localparam longint RUN_LIMIT_NS  = 64'd20_000_000;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // One interpolated answer as the result channel should present it.
   typedef struct {
      logic signed [VALUE_W-1:0] rho;
      logic signed [VALUE_W-1:0] vel;
      logic signed [VALUE_W-1:0] sigma;
      tbli_pkg::status_type      status;
   } interp_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;

   tbli_req_if req_chan ();
   tbli_rsp_if rsp_chan ();

   table_bisect_linear_interp dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Our own copy of the table and of the row count register. Rows change
   // only when a load transfer is accepted, and the count only on a write.
   tbli_pkg::row_type   table_rows [TABLE_DEPTH];
   logic [COUNT_W-1:0]  row_count;
   interp_result_type   pending_results [$];

   // Idling controls. The sender skips a cycle with probability
   // send_idle_pct in a hundred, and the receiver drops ready likewise.
   // A non-zero hold_off_cycles keeps ready low until it has counted down.
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_off_cycles = 0;
   int mismatch_count  = 0;

   always #CLOCK_HALF clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic longint unsigned rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic longint time_of(input int row);
      return longint'($signed(table_rows[row].time_val));
   endfunction

   // A count above the table depth behaves as a full table.
   function automatic int active_rows();
      return (row_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(row_count);
   endfunction

   // Weighted mix of two row values by a fraction with FRAC_BITS bits below
   // the point. The shift is arithmetic, so negative sums round downwards.
   function automatic logic signed [VALUE_W-1:0] blend_value(
      input logic signed [VALUE_W-1:0] low_v,
      input logic signed [VALUE_W-1:0] high_v,
      input longint                    frac
   );
      longint acc;
      acc = longint'(low_v) * ((longint'(1) << FRAC_BITS) - frac) + longint'(high_v) * frac;
      acc = acc >>> FRAC_BITS;
      return acc[VALUE_W-1:0];
   endfunction

   // Works out the answer to a query against the current table and count.
   function automatic interp_result_type interpolate(input logic signed [VALUE_W-1:0] qt);
      interp_result_type res;
      int              rows;
      int              low;
      int              high;
      int              mid;
      longint          t;
      longint          offset;
      longint          width;
      longint unsigned num;
      longint unsigned den;
      longint          frac;
      res.rho    = '0;
      res.vel    = '0;
      res.sigma  = '0;
      res.status = tbli_pkg::STATUS_OK;
      rows = active_rows();
      t    = longint'(qt);
      if (rows == 0 || t < time_of(0) || t > time_of(rows - 1)) begin
         res.status = tbli_pkg::STATUS_RANGE;
         return res;
      end
      low  = 0;
      high = rows - 1;
      while (high - low > 1) begin
         mid = (high + low) / 2;
         if (t < time_of(mid)) begin
            high = mid;
         end else begin
            low = mid;
         end
      end
      width  = time_of(high) - time_of(low);
      offset = t - time_of(low);
      if (width == 0) begin
         res.status = tbli_pkg::STATUS_ZERO_BIN;
         return res;
      end
      // The fraction is clamped to the range zero to one, and is zero when
      // the offset and the bin width point in opposite directions.
      if (offset == 0 || ((offset < 0) != (width < 0))) begin
         frac = 0;
      end else begin
         num = (offset < 0) ? -offset : offset;
         den = (width < 0) ? -width : width;
         if (num >= den) begin
            frac = longint'(1) << FRAC_BITS;
         end else begin
            frac = longint'((num << FRAC_BITS) / den);
         end
      end
      res.rho   = blend_value(table_rows[low].rho, table_rows[high].rho, frac);
      res.vel   = blend_value(table_rows[low].vel, table_rows[high].vel, frac);
      res.sigma = blend_value(table_rows[low].sigma, table_rows[high].sigma, frac);
      return res;
   endfunction

   // Picks a query time. Most land inside a bin of the present table or on a
   // row time; a few sit just outside the ends or anywhere at all.
   function automatic logic signed [VALUE_W-1:0] pick_query_time();
      int     rows;
      int     row;
      int     sel;
      longint lo;
      longint hi;
      longint t;
      rows = active_rows();
      sel  = $urandom_range(0, 99);
      if (rows == 0 || sel < 10) begin
         t = longint'($urandom);
      end else if (sel < 16) begin
         t = sel[0] ? time_of(0) - 1 : time_of(rows - 1) + 1;
      end else begin
         row = $urandom_range(0, rows - 1);
         lo  = time_of(row);
         hi  = (row < rows - 1) ? time_of(row + 1) : lo;
         if (sel < 30 || hi <= lo) begin
            t = lo;
         end else begin
            t = lo + longint'(rand64() % (hi - lo + 1));
         end
      end
      return t[VALUE_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Offers one item on the request channel at a falling edge, after any
   // random idle cycles, and holds it until the transfer is seen at a rising
   // edge. The table copy and the queue of expected answers are updated at
   // that edge, so the prediction follows the order of acceptance.
   task automatic send_item(
      input tbli_pkg::func_type        func,
      input logic [INDEX_W-1:0]        idx,
      input logic signed [VALUE_W-1:0] t,
      input logic signed [VALUE_W-1:0] rho,
      input logic signed [VALUE_W-1:0] vel,
      input logic signed [VALUE_W-1:0] sigma,
      input logic signed [VALUE_W-1:0] qt
   );
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.func        = func;
      req_chan.entry_index = idx;
      req_chan.entry_time  = t;
      req_chan.entry_rho   = rho;
      req_chan.entry_vel   = vel;
      req_chan.entry_sigma = sigma;
      req_chan.query_time  = qt;
      do begin
         @(posedge clock);
      end while (req_chan.ready !== 1'b1);
      if (func == tbli_pkg::FUNC_LOAD) begin
         table_rows[idx].time_val = t;
         table_rows[idx].rho      = rho;
         table_rows[idx].vel      = vel;
         table_rows[idx].sigma    = sigma;
      end else begin
         pending_results.push_back(interpolate(qt));
      end
   endtask

   // A load carries a random query time and a query carries a random row, so
   // the fields that an item does not use are exercised as well.
   task automatic load_row(
      input int                        idx,
      input logic signed [VALUE_W-1:0] t,
      input logic signed [VALUE_W-1:0] rho,
      input logic signed [VALUE_W-1:0] vel,
      input logic signed [VALUE_W-1:0] sigma
   );
      send_item(tbli_pkg::FUNC_LOAD, idx[INDEX_W-1:0], t, rho, vel, sigma, $urandom);
   endtask

   task automatic query_at(input logic signed [VALUE_W-1:0] qt);
      send_item(tbli_pkg::FUNC_QUERY, INDEX_W'($urandom), $urandom, $urandom, $urandom,
                $urandom, qt);
   endtask

   // Drops valid, waits for every expected answer and then lets the block
   // settle, since a load just accepted produces no answer to wait for.
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The count register is only ever written while the block is idle.
   task automatic write_row_count(input logic [COUNT_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      row_count = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Loads rows 0 upwards with ascending times and random values. The step
   // scale varies from tiny to one that spreads the rows over the whole
   // signed range, and a few steps are zero so that empty bins appear.
   task automatic load_sorted_table(input int rows);
      longint stride;
      longint room;
      longint t;
      int     row;
      case ($urandom_range(0, 3))
         0: stride = 4;
         1: stride = longint'(1) << 12;
         2: stride = longint'(1) << 20;
         default: stride = (longint'(1) << 32) / (rows + 1);
      endcase
      room = (longint'(1) << 32) - 1 - (rows - 1) * stride;
      t    = longint'(VALUE_MIN) + longint'(rand64() % (room + 1));
      for (row = 0; row < rows; row++) begin
         if (row > 0 && $urandom_range(0, 99) >= 6) begin
            t = t + longint'(rand64() % (stride + 1));
         end
         load_row(row, t[VALUE_W-1:0], $urandom, $urandom, $urandom);
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver and checking
   // ------------------------------------------------------------------

   // Ready changes at the falling edge. A hold-off request wins over the
   // random stalls and is counted down here, one cycle at a time.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_chan.ready  = 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_chan.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic compare_field(input string field, input longint want_v, input longint got_v);
      if (want_v !== got_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      end
   endtask

   // Every result transfer is matched against the oldest expected answer.
   always @(posedge clock) begin : check_results
      interp_result_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result mismatch, expected no result, actual status %0d",
                     $time, rsp_chan.status);
         end else begin
            want = pending_results.pop_front();
            compare_field("out_rho", longint'(want.rho), longint'(rsp_chan.out_rho));
            compare_field("out_vel", longint'(want.vel), longint'(rsp_chan.out_vel));
            compare_field("out_sigma", longint'(want.sigma), longint'(rsp_chan.out_sigma));
            compare_field("status", longint'(want.status), longint'(rsp_chan.status));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // After reset the count is zero, so every query reports out of range.
   task automatic test_empty_table();
      query_at(VALUE_MIN);
      query_at(VALUE_MAX);
   endtask

   // With a single row, a query at its time finds a zero-width bin and any
   // other time is outside the table.
   task automatic test_single_row();
      load_row(0, 1234, VALUE_MAX, VALUE_MIN, 77);
      write_row_count(COUNT_W'(1));
      query_at(1234);
      query_at(1233);
      query_at(1235);
   endtask

   // Times and values at both ends of the signed range. The two last rows
   // share the largest time, so a query there lands in an empty bin; a query
   // just below zero gives a fraction near one across the widest bin.
   task automatic test_extreme_values();
      load_row(0, VALUE_MIN, VALUE_MIN, VALUE_MAX, 0);
      load_row(1, 0, VALUE_MAX, VALUE_MIN, -1);
      load_row(2, VALUE_MAX, VALUE_MIN, VALUE_MAX, 32'sh1234_5678);
      load_row(3, VALUE_MAX, VALUE_MAX, VALUE_MIN, VALUE_MIN);
      write_row_count(COUNT_W'(4));
      query_at(VALUE_MIN);
      query_at(-1);
      query_at(1);
      query_at(32'sh4000_0000);
      query_at(VALUE_MAX);
   endtask

   // Rows out of time order. Bisection still brackets the query, and a query
   // on the last row time drives the fraction to its upper clamp.
   task automatic test_unsorted_rows();
      load_row(0, 0, 100, -100, 5);
      load_row(1, 3000, -200, 300, 6);
      load_row(2, 1000, 400, -500, 7);
      load_row(3, 4000, -600, 700, 8);
      write_row_count(COUNT_W'(4));
      query_at(3500);
      query_at(500);
      query_at(4000);
   endtask

   // Full table, then a count beyond the table depth, which must act as
   // a full table. Every row index is written here, so later tests may
   // choose any count without reading a row that was never loaded.
   task automatic test_full_table();
      int k;
      load_sorted_table(TABLE_DEPTH);
      write_row_count(COUNT_W'(TABLE_DEPTH));
      for (k = 0; k < 40; k++) begin
         query_at(pick_query_time());
      end
      write_row_count({COUNT_W{1'b1}});
      for (k = 0; k < 20; k++) begin
         query_at(pick_query_time());
      end
   endtask

   // The receiver holds off for a long stretch while queries keep coming,
   // so the output register fills, a second query waits in its last state
   // and the request channel stops taking transfers.
   task automatic test_output_backpressure();
      int k;
      send_idle_pct   = 0;
      stall_pct       = 0;
      hold_off_cycles = 400;
      for (k = 0; k < 8; k++) begin
         if (k == 3) begin
            load_row($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom, $urandom, $urandom);
         end
         query_at(pick_query_time());
      end
      drain_results();
   endtask

   // Random traffic at one setting of sender idling and receiver stalls.
   // Each round loads a fresh sorted table, sets a count and then mixes
   // queries, mostly aimed inside the table, with loads that rewrite a row.
   // A rewritten row usually keeps its place in time order, but not always.
   task automatic test_random_traffic(input int idle_pct, input int stall_in);
      int                  round;
      int                  k;
      int                  sel;
      int                  rows;
      int                  idx;
      longint              lo;
      longint              hi;
      longint              t;
      logic [COUNT_W-1:0]  new_count;
      send_idle_pct = idle_pct;
      stall_pct     = stall_in;
      for (round = 0; round < 2; round++) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            new_count = COUNT_W'(TABLE_DEPTH);
         end else if (sel == 1) begin
            new_count = '0;
         end else if (sel == 2) begin
            new_count = COUNT_W'(1);
         end else begin
            new_count = COUNT_W'($urandom_range(2, 48));
         end
         load_sorted_table(int'(new_count));
         write_row_count(new_count);
         rows = active_rows();
         for (k = 0; k < 90; k++) begin
            if ($urandom_range(0, 99) < 12) begin
               if (rows == 0 || $urandom_range(0, 99) < 30) begin
                  idx = $urandom_range(0, TABLE_DEPTH - 1);
               end else begin
                  idx = $urandom_range(0, rows - 1);
               end
               lo = (idx > 0) ? time_of(idx - 1) : longint'(VALUE_MIN);
               hi = (idx + 1 < rows) ? time_of(idx + 1) : longint'(VALUE_MAX);
               if (idx < rows && lo <= hi) begin
                  t = lo + longint'(rand64() % (hi - lo + 1));
               end else begin
                  t = longint'($urandom);
               end
               load_row(idx, t[VALUE_W-1:0], $urandom, $urandom, $urandom);
            end else begin
               query_at(pick_query_time());
            end
         end
         drain_results();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.func        = tbli_pkg::FUNC_LOAD;
      req_chan.entry_index = '0;
      req_chan.entry_time  = '0;
      req_chan.entry_rho   = '0;
      req_chan.entry_vel   = '0;
      req_chan.entry_sigma = '0;
      req_chan.query_time  = '0;
      rsp_chan.ready       = 1'b0;
      row_count            = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_single_row();
      test_extreme_values();
      test_unsorted_rows();
      test_full_table();
      test_output_backpressure();
      test_random_traffic(0, 0);
      test_random_traffic(82, 0);
      test_random_traffic(0, 82);
      test_random_traffic(24, 24);

      drain_results();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Guards against a block that stops answering or stops taking transfers.
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
